// ===== design/wbps_pkg.sv =====
// Package for the wildcard byte pattern search core: widths, register indexes, helpers.
`timescale 1ns / 1ps
`default_nettype none
package wbps_pkg;

    // Default and upper bound of the window depth
    localparam int PATTERN_MAX_DEFAULT = 16;
    localparam int PATTERN_MAX_LIMIT   = 64;

    // Width of a pattern position index, enough for the upper bound
    localparam int POS_W    = $clog2(PATTERN_MAX_LIMIT + 1);
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int OFFSET_W = 32;
    localparam int LENREG_W = 5;
    localparam int MASK_W   = 16;
    localparam int BYTE_W   = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_MASK  = 2'd3;

    // One result item
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } result_t;

    // Pattern byte k; positions beyond the two 64-bit registers read as zero
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [POS_W-1:0] k,
        input logic [CFG_W-1:0] low,
        input logic [CFG_W-1:0] high
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        if (k < POS_W'(8)) begin
            b = low[k[2:0]*BYTE_W +: BYTE_W];
        end else if (k < POS_W'(16)) begin
            b = high[k[2:0]*BYTE_W +: BYTE_W];
        end
        return b;
    endfunction

    // Wildcard flag of position k; positions beyond the mask are never wildcards
    function automatic logic is_wildcard(
        input logic [POS_W-1:0]  k,
        input logic [MASK_W-1:0] mask
    );
        logic w;
        w = 1'b0;
        if (k < POS_W'(MASK_W)) begin
            w = mask[k[3:0]];
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== design/wbps_cell.sv =====
// One window cell: holds one byte of the window, passes it on and compares the incoming byte.
`timescale 1ns / 1ps
`default_nettype none
module wbps_cell
    import wbps_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              shift_en,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic              cmp_en,
    input  wire logic [BYTE_W-1:0] pat_byte,
    output logic      [BYTE_W-1:0] byte_out,
    output logic                   cell_ok
);

    logic [BYTE_W-1:0] byte_reg;

    // Take the neighbour's byte whenever shift_en is high
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Compare the byte that lands here this cycle against the aligned pattern byte
    assign cell_ok = !cmp_en || (byte_in == pat_byte);

endmodule
`default_nettype wire

// ===== design/wbps_out_buf.sv =====
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps
`default_nettype none
module wbps_out_buf
    import wbps_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output result_t      m_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    take;

    assign take = out_valid_reg && m_tready;

    // Refill the output register from the skid stage first, then from a new request
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end else begin
                out_valid_next  = push;
                out_data_next   = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full     = skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_data   = out_data_reg;

endmodule
`default_nettype wire

// ===== design/wildcard_byte_pattern_search_core.sv =====
// Top level of the wildcard byte pattern search core: window cell chain, counter, result buffer.
//
// Usage: load pattern_length (index 0), pattern bytes 0-7 (index 1), pattern bytes
// 8-15 (index 2) and the wildcard mask (index 3) through cfg_wr_en / cfg_index /
// cfg_wdata while the core is idle. Then stream the source buffer in, one byte per
// request on s_tdata, with s_tlast high on the final byte.
// Each accepted byte shifts through a chain of PATTERN_MAX cells until a match is
// reported; every cell compares the byte it receives against its aligned pattern byte,
// and the cell results are combined in the same cycle. The core takes one byte per
// cycle while s_tready is high. A result (found on m_tuser plus start offset on m_tdata,
// or not found on the final byte) is registered in the result buffer before it appears
// on the m_ channel. Bytes after a match give no result; the final byte clears the count
// and the match flag. Results pass through an output register and a skid stage, so the
// input keeps flowing while one result waits; s_tready drops only while both entries are full.
// Reset (aresetn low, synchronous) empties the result buffer, clears the count and
// the match flag, and returns the registers to length 1, pattern zero, no wildcards.
`timescale 1ns / 1ps
`default_nettype none
module wildcard_byte_pattern_search_core
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // Input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,  // [7:0] data_byte
    input  wire logic                 s_tlast,  // last_byte
    // Result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [31:0]          m_tdata,  // [31:0] match_offset
    output logic                      m_tuser   // [0] found
);

    localparam int LEN_W = ($clog2(PATTERN_MAX + 1) > LENREG_W) ?
                           $clog2(PATTERN_MAX + 1) : LENREG_W;

    logic [LENREG_W-1:0] pattern_length_reg;
    logic [CFG_W-1:0]    pattern_low_reg;
    logic [CFG_W-1:0]    pattern_high_reg;
    logic [MASK_W-1:0]   wildcard_mask_reg;

    logic [OFFSET_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic                match_reported_reg, match_reported_next;

    logic [LEN_W-1:0]    len_used;
    logic                accept;
    logic                scan;
    logic                hit;
    logic                push;
    result_t             push_data;
    result_t             out_data;
    logic                buf_full;

    logic [BYTE_W-1:0]      chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_ok;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LENREG_W'(1);
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[LENREG_W-1:0];
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                REG_WILDCARD_MASK:  wildcard_mask_reg  <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the length to 1..PATTERN_MAX
    always_comb begin
        len_used = LEN_W'(pattern_length_reg);
        if (pattern_length_reg == '0) begin
            len_used = LEN_W'(1);
        end else if (len_used > LEN_W'(PATTERN_MAX)) begin
            len_used = LEN_W'(PATTERN_MAX);
        end
    end

    assign s_tready = !buf_full;
    assign accept   = s_tvalid && s_tready;
    assign scan     = accept && !match_reported_reg;

    // Build the cell chain; cell j checks pattern position len-1-j
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic [BYTE_W-1:0] cell_in;
        logic [LEN_W-1:0]  pos;
        logic [POS_W-1:0]  pos_ext;
        logic              in_use;

        assign in_use  = LEN_W'(j) < len_used;
        assign pos     = len_used - LEN_W'(1) - LEN_W'(j);
        assign pos_ext = POS_W'(pos);

        if (j == 0) begin : g_head
            assign cell_in = s_tdata;
        end else begin : g_body
            assign cell_in = chain[j-1];
        end

        wbps_cell u_cell (
            .aclk     (aclk),
            .shift_en (scan),
            .byte_in  (cell_in),
            .cmp_en   (in_use && !is_wildcard(pos_ext, wildcard_mask_reg)),
            .pat_byte (pattern_byte(pos_ext, pattern_low_reg, pattern_high_reg)),
            .byte_out (chain[j]),
            .cell_ok  (cell_ok[j])
        );
    end

    // Count bytes with saturation and decide the result
    always_comb begin
        bytes_seen_next     = bytes_seen_reg;
        match_reported_next = match_reported_reg;
        hit                 = 1'b0;
        push                = 1'b0;
        push_data.found        = 1'b0;
        push_data.match_offset = '0;
        if (scan) begin
            if (bytes_seen_reg != '1) begin
                bytes_seen_next = bytes_seen_reg + OFFSET_W'(1);
            end
            hit = (&cell_ok) && (bytes_seen_next >= OFFSET_W'(len_used));
            if (hit) begin
                match_reported_next    = 1'b1;
                push                   = 1'b1;
                push_data.found        = 1'b1;
                push_data.match_offset = bytes_seen_next - OFFSET_W'(len_used);
            end else if (s_tlast) begin
                push = 1'b1;
            end
        end
        // Clear the buffer state on the final byte
        if (accept && s_tlast) begin
            bytes_seen_next     = '0;
            match_reported_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg     <= '0;
            match_reported_reg <= 1'b0;
        end else begin
            bytes_seen_reg     <= bytes_seen_next;
            match_reported_reg <= match_reported_next;
        end
    end

    // Hold results until the receiver takes them
    wbps_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = out_data.match_offset;
    assign m_tuser = out_data.found;

endmodule
`default_nettype wire

// ===== verif/tb_wildcard_byte_pattern_search_core.sv =====
// Self-checking testbench for the wildcard byte pattern search core.
`timescale 1ns / 1ps
module tb_wildcard_byte_pattern_search_core;
    import wbps_pkg::*;

    // Directed table: register writes and bytes, some with the result typed in
    typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      value;
        logic [7:0]            data;
        logic                  is_last;
        logic                  typed;
        logic                  has_res;
        logic                  exp_found;
        logic [OFFSET_W-1:0]   exp_offset;
    } stim_row_t;

    localparam int DIR_N = 32;
    localparam stim_row_t DIR_ROWS [0:DIR_N-1] = '{
        // after reset: length 1, pattern byte zero
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
        // zero length behaves as one
        '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_WRITE, REG_PATTERN_LOW,  64'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0},
        // two bytes, first one a wildcard
        '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_WRITE, REG_PATTERN_LOW, 64'hCDAB, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_WRITE, REG_WILDCARD_MASK, 64'd1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'h12, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hCD, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
        // exact match one byte in
        '{ROW_WRITE, REG_WILDCARD_MASK, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hAB, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hAB, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hCD, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
        // oversized length clamps to the window; buffer shorter than pattern
        '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
        // pattern spanning both pattern registers, all ones
        '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd9, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_WRITE, REG_PATTERN_LOW,  '1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_WRITE, REG_PATTERN_HIGH, '1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE,  REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0}
    };

    localparam int SETTINGS_N   = 12;
    localparam int BYTES_PER_SET = 140;
    localparam int HOLD_CYCLES  = 400;

    // DUT ports
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;  // [7:0] data_byte
    logic                 s_tlast   = 1'b0; // last_byte
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;          // [31:0] match_offset
    logic                 m_tuser;          // [0] found

    // Typed expectation travelling with the request on the input side
    logic    row_typed = 1'b0;
    logic    row_has   = 1'b0;
    result_t row_res   = '0;

    // Search model state and its copy of the registers
    logic [7:0]          win_bytes [16];
    logic [31:0]         byte_count;
    logic                matched;
    logic [LENREG_W-1:0] len_reg;
    logic [CFG_W-1:0]    pat_lo;
    logic [CFG_W-1:0]    pat_hi;
    logic [MASK_W-1:0]   wild_mask;

    result_t results_due [$];
    int      err_count = 0;

    // Idling controls and the long receiver hold-off
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    wildcard_byte_pattern_search_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Length in use after clamping
    function automatic int unsigned eff_len();
        int unsigned n;
        n = 32'(len_reg);
        if (n == 0) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    function automatic logic [7:0] pat_at(input int k);
        if (k < 8) return pat_lo[8*k +: 8];
        return pat_hi[8*(k-8) +: 8];
    endfunction

    task automatic clear_window();
        int k;
        for (k = 0; k < 16; k++) win_bytes[k] = 8'h00;
        byte_count = '0;
        matched    = 1'b0;
    endtask

    // Shift one byte into the window and work out the result it causes
    task automatic advance_search(input logic [7:0] d, input logic is_last,
                                  output logic has, output result_t res);
        int unsigned n;
        int k;
        logic hit;
        has = 1'b0;
        res = '0;
        if (!matched) begin
            n = eff_len();
            for (k = 15; k > 0; k--) win_bytes[k] = win_bytes[k-1];
            win_bytes[0] = d;
            if (byte_count != 32'hFFFF_FFFF) byte_count++;
            hit = (byte_count >= n);
            for (k = 0; k < n; k++) begin
                if (!wild_mask[k] && pat_at(k) != win_bytes[n-1-k]) hit = 1'b0;
            end
            if (hit) begin
                matched          = 1'b1;
                has              = 1'b1;
                res.found        = 1'b1;
                res.match_offset = byte_count - n;
            end else if (is_last) begin
                has = 1'b1;
            end
        end
        if (is_last) clear_window();
    endtask

    // Predict on every accepted byte, compare every accepted result
    always @(posedge aclk) begin : scoreboard
        logic    model_has;
        result_t model_res;
        result_t got;
        result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                advance_search(s_tdata, s_tlast, model_has, model_res);
                if (row_typed) begin
                    if (row_has) results_due = {results_due, row_res};
                end else if (model_has) begin
                    results_due = {results_due, model_res};
                end
            end
            if (m_tvalid && m_tready) begin
                got.found        = m_tuser;
                got.match_offset = m_tdata;
                if (results_due.size() == 0) begin
                    $error("unexpected result: found %0d, match_offset %0d",
                           got.found, got.match_offset);
                    err_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                        err_count++;
                    end
                    if (got.match_offset !== want.match_offset) begin
                        $error("match_offset: expected %0d, actual %0d",
                               want.match_offset, got.match_offset);
                        err_count++;
                    end
                end
            end
        end
    end

    // Result side: random stalls, or a long hold-off when asked for
    always @(posedge aclk) begin : sink
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one request and hold it until accepted, then maybe idle
    task automatic send_byte(input logic [7:0] d, input logic is_last,
                             input logic typed, input logic has, input result_t res);
        s_tvalid  <= 1'b1;
        s_tdata   <= d;
        s_tlast   <= is_last;
        row_typed <= typed;
        row_has   <= has;
        row_res   <= res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Write a register once the core has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PATTERN_LENGTH: len_reg   = val[LENREG_W-1:0];
            REG_PATTERN_LOW:    pat_lo    = val;
            REG_PATTERN_HIGH:   pat_hi    = val;
            REG_WILDCARD_MASK:  wild_mask = val[MASK_W-1:0];
            default: ;
        endcase
    endtask

    // Build one buffer: mostly with the pattern planted, some near misses, some noise
    task automatic send_buffer(input int blen);
        logic [7:0] bytes_q [$];
        int i, k, at, mode;
        int unsigned n;
        n    = eff_len();
        mode = $urandom_range(99);
        for (i = 0; i < blen; i++) begin
            if (mode < 15 || $urandom_range(1) == 0) begin
                bytes_q = {bytes_q, 8'($urandom_range(255))};
            end else begin
                bytes_q = {bytes_q, pat_at(int'($urandom_range(n - 1)))};
            end
        end
        if (mode >= 15 && blen >= n) begin
            at = int'($urandom_range(blen - n));
            for (k = 0; k < n; k++) begin
                if (wild_mask[k]) bytes_q[at+k] = 8'($urandom_range(255));
                else bytes_q[at+k] = pat_at(k);
            end
            // near miss: spoil one position
            if (mode < 30) begin
                k = int'($urandom_range(n - 1));
                bytes_q[at+k] = bytes_q[at+k] ^ (8'h01 << $urandom_range(7));
            end
        end
        for (i = 0; i < blen; i++) send_byte(bytes_q[i], i == blen - 1, 1'b0, 1'b0, '0);
    endtask

    initial begin : stimulus
        int i, setting, sent, blen, r;
        int unsigned n;
        logic [CFG_W-1:0] v;
        logic [LENREG_W-1:0] len_pick;
        len_reg   = 5'd1;
        pat_lo    = '0;
        pat_hi    = '0;
        wild_mask = '0;
        clear_window();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        for (i = 0; i < DIR_N; i++) begin
            if (DIR_ROWS[i].kind == ROW_WRITE) begin
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value);
            end else begin
                send_byte(DIR_ROWS[i].data, DIR_ROWS[i].is_last, DIR_ROWS[i].typed,
                          DIR_ROWS[i].has_res,
                          '{found: DIR_ROWS[i].exp_found,
                            match_offset: DIR_ROWS[i].exp_offset});
            end
        end

        // Random part: one register setting and one idling phase per stretch
        for (setting = 0; setting < SETTINGS_N; setting++) begin
            case (setting)
                0: len_pick = 5'd16;
                1: len_pick = 5'd1;
                2: len_pick = 5'd1;
                3: len_pick = 5'd0;
                4: len_pick = 5'd31;
                default: begin
                    if ($urandom_range(99) < 80) len_pick = LENREG_W'($urandom_range(16, 1));
                    else len_pick = LENREG_W'($urandom_range(31));
                end
            endcase
            // upper bits of the narrow registers carry junk
            v = {$urandom, $urandom};
            v[LENREG_W-1:0] = len_pick;
            write_reg(REG_PATTERN_LENGTH, v);
            write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
            write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
            v = {$urandom, $urandom};
            if (setting == 1) v[MASK_W-1:0] = '0;
            else if (setting == 2) v[MASK_W-1:0] = 16'h0001;
            else if ($urandom_range(3) == 0) v[MASK_W-1:0] = MASK_W'($urandom_range(65535));
            else v[MASK_W-1:0] = MASK_W'($urandom_range(65535) & $urandom_range(65535));
            write_reg(REG_WILDCARD_MASK, v);

            case (setting % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase

            // Hold the receiver off while one-byte matching buffers keep coming
            if (setting == 2) begin
                idle_pct  = 0;
                stall_pct = 0;
                hold_token++;
            end

            n    = eff_len();
            sent = 0;
            while (sent < BYTES_PER_SET) begin
                r = $urandom_range(99);
                if (setting == 2 || r < 10) blen = 1;
                else if (r < 85) blen = $urandom_range(n + 12, 1);
                else blen = $urandom_range(64, 1);
                send_buffer(blen);
                sent += blen;
            end
        end

        // Drain and finish
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_wildcard_byte_pattern_search_core: done, clean");
        end else begin
            $display("tb_wildcard_byte_pattern_search_core: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb_wildcard_byte_pattern_search_core: done, errors");
        $finish;
    end

endmodule
